@@ hw/rtl/eight_bit_accumulator_alu_with_flags_top_assert.svh @@
// Assertion macros shared by the accumulator ALU RTL.
`ifndef EIGHT_BIT_ACCUMULATOR_ALU_WITH_FLAGS_TOP_ASSERT_SVH
`define EIGHT_BIT_ACCUMULATOR_ALU_WITH_FLAGS_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ACC_ALU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("acc_alu: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define ACC_ALU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("acc_alu: next-cycle check failed");

`endif

@@ hw/rtl/acc_alu_pkg.sv @@
package acc_alu_pkg;

  typedef enum logic [4:0] {
    OpAdd = 5'd0,
    OpAdc = 5'd1,
    OpSub = 5'd2,
    OpSbb = 5'd3,
    OpAna = 5'd4,
    OpXra = 5'd5,
    OpOra = 5'd6,
    OpCmp = 5'd7,
    OpRlc = 5'd8,
    OpRrc = 5'd9,
    OpRal = 5'd10,
    OpRar = 5'd11,
    OpDad = 5'd12,
    OpInr = 5'd13,
    OpDcr = 5'd14,
    OpCma = 5'd15,
    OpDaa = 5'd16,
    OpInx = 5'd17,
    OpDcx = 5'd18,
    OpCmc = 5'd19,
    OpStc = 5'd20
  } op_e;

  typedef struct packed {
    logic s;
    logic z;
    logic ac;
    logic p;
    logic cy;
  } flags_t;

  localparam logic [7:0] DaaLowCorr  = 8'h06;
  localparam logic [7:0] DaaHighCorr = 8'h60;
  localparam logic [3:0] BcdDigitMax = 4'd9;
  localparam logic [3:0] NibbleAllOnes = 4'hf;

  // Sign, zero and even parity of a byte; aux carry and carry left clear.
  function automatic flags_t szp(input logic [7:0] v);
    flags_t f;
    f    = '0;
    f.s  = v[7];
    f.z  = (v == 8'h00);
    f.p  = ~^v;
    return f;
  endfunction

endpackage

@@ hw/rtl/eight_bit_accumulator_alu_with_flags_top.sv @@
// Accumulator ALU with sign, zero, aux-carry, parity and carry flags.
// Input channel: in_valid_i / in_stall_o carry one operation word (operation,
// byte operand, pair operand); a word is taken at a rising edge with valid
// high and stall low. Output channel: out_valid_o / out_stall_i carry one
// result word per operation: accumulator, five flags, the stored pair and
// the inr/dcr and inx/dcx results.
// A taken word waits in the input register, then its result goes to the state
// and the output register. Throughput: one word per cycle while the output is
// not stalled, set by the single execute stage that reads and writes the
// accumulator, flags and pair in the same cycle it loads the output register.
// Stalls: while the output is stalled the result and the architectural
// state hold; one more word waits in the input register, after which
// in_stall_o rises. Stall passes back combinationally by one stage.
// Reset: accumulator, pair and all flags clear; both stages empty.
`include "eight_bit_accumulator_alu_with_flags_top_assert.svh"

module eight_bit_accumulator_alu_with_flags_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [4:0]  operation_i,
  input  logic [7:0]  operand_byte_i,
  input  logic [15:0] operand_pair_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  acc_out_o,
  output logic        sign_flag_o,
  output logic        zero_flag_o,
  output logic        aux_carry_flag_o,
  output logic        parity_flag_o,
  output logic        carry_flag_o,
  output logic [15:0] pair_out_o,
  output logic [7:0]  byte_result_o,
  output logic [15:0] pair_result_o
);

  // Input register stage
  logic        in_valid_q;
  logic [4:0]  op_q;
  logic [7:0]  byte_q;
  logic [15:0] pair_op_q;

  // Architectural state, doubling as the visible part of the result word
  logic [7:0]           acc_q, acc_d;
  acc_alu_pkg::flags_t  flags_q, flags_d;
  logic [15:0]          pair_q, pair_d;

  // Output register stage
  logic        out_valid_q;
  logic [7:0]  byte_res_q, byte_res_d;
  logic [15:0] pair_res_q, pair_res_d;

  logic in_accept;
  logic advance;
  logic execute;

  // Advance the pipe whenever the output register is free or being taken.
  assign advance    = !out_valid_q || !out_stall_i;
  assign execute    = advance && in_valid_q;
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  // Hold the input word until it moves into the execute stage.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q      <= operation_i;
      byte_q    <= operand_byte_i;
      pair_op_q <= operand_pair_i;
    end
  end

  // Shared 8-bit adder: add, adc, sub, sbb, cmp and the daa correction.
  logic                is_sub;
  logic                is_daa;
  logic                carry_in_raw;
  logic                carry_in;
  logic [7:0]          addend;
  logic [8:0]          sum9;
  logic [4:0]          low5;
  acc_alu_pkg::flags_t add_flags;
  logic [7:0]          daa_corr;
  logic                daa_low_big;
  logic                daa_cy;
  logic [16:0]         dad_sum;

  assign is_sub = (op_q == acc_alu_pkg::OpSub) || (op_q == acc_alu_pkg::OpSbb)
               || (op_q == acc_alu_pkg::OpCmp);
  assign is_daa = (op_q == acc_alu_pkg::OpDaa);
  assign carry_in_raw = ((op_q == acc_alu_pkg::OpAdc) || (op_q == acc_alu_pkg::OpSbb))
                        ? flags_q.cy : 1'b0;
  // Subtract as a + ~b + !borrow_in.
  assign carry_in = is_sub ? ~carry_in_raw : carry_in_raw;

  assign daa_low_big = (acc_q[3:0] > acc_alu_pkg::BcdDigitMax);
  assign daa_cy = flags_q.cy || (acc_q[7:4] > acc_alu_pkg::BcdDigitMax)
               || ((acc_q[7:4] >= acc_alu_pkg::BcdDigitMax) && daa_low_big);
  assign daa_corr = ((flags_q.ac || daa_low_big) ? acc_alu_pkg::DaaLowCorr : 8'h00)
                  | (daa_cy ? acc_alu_pkg::DaaHighCorr : 8'h00);

  assign addend = is_daa ? daa_corr : (is_sub ? ~byte_q : byte_q);
  assign sum9   = {1'b0, acc_q} + {1'b0, addend} + {8'b0, carry_in};
  assign low5   = {1'b0, acc_q[3:0]} + {1'b0, addend[3:0]} + {4'b0, carry_in};

  always_comb begin
    add_flags    = acc_alu_pkg::szp(sum9[7:0]);
    add_flags.ac = low5[4];
    // Carry out inverted is the borrow when subtracting.
    add_flags.cy = sum9[8] ^ is_sub;
  end

  assign dad_sum = {1'b0, pair_q} + {1'b0, pair_op_q};

  always_comb begin
    acc_d      = acc_q;
    flags_d    = flags_q;
    pair_d     = pair_q;
    byte_res_d = '0;
    pair_res_d = '0;
    unique case (acc_alu_pkg::op_e'(op_q))
      acc_alu_pkg::OpAdd, acc_alu_pkg::OpAdc,
      acc_alu_pkg::OpSub, acc_alu_pkg::OpSbb: begin
        acc_d   = sum9[7:0];
        flags_d = add_flags;
      end
      acc_alu_pkg::OpCmp: begin
        flags_d = add_flags;
      end
      acc_alu_pkg::OpAna: begin
        acc_d   = acc_q & byte_q;
        flags_d = acc_alu_pkg::szp(acc_q & byte_q);
      end
      acc_alu_pkg::OpXra: begin
        acc_d   = acc_q ^ byte_q;
        flags_d = acc_alu_pkg::szp(acc_q ^ byte_q);
      end
      acc_alu_pkg::OpOra: begin
        acc_d   = acc_q | byte_q;
        flags_d = acc_alu_pkg::szp(acc_q | byte_q);
      end
      acc_alu_pkg::OpRlc: begin
        acc_d      = {acc_q[6:0], acc_q[7]};
        flags_d.cy = acc_q[7];
      end
      acc_alu_pkg::OpRrc: begin
        acc_d      = {acc_q[0], acc_q[7:1]};
        flags_d.cy = acc_q[0];
      end
      acc_alu_pkg::OpRal: begin
        acc_d      = {acc_q[6:0], flags_q.cy};
        flags_d.cy = acc_q[7];
      end
      acc_alu_pkg::OpRar: begin
        acc_d      = {flags_q.cy, acc_q[7:1]};
        flags_d.cy = acc_q[0];
      end
      acc_alu_pkg::OpDad: begin
        pair_d     = dad_sum[15:0];
        flags_d.cy = dad_sum[16];
      end
      acc_alu_pkg::OpInr: begin
        byte_res_d = byte_q + 8'd1;
        flags_d    = acc_alu_pkg::szp(byte_q + 8'd1);
        flags_d.cy = flags_q.cy;
        flags_d.ac = (byte_q[3:0] == acc_alu_pkg::NibbleAllOnes);
      end
      acc_alu_pkg::OpDcr: begin
        byte_res_d = byte_q - 8'd1;
        flags_d    = acc_alu_pkg::szp(byte_q - 8'd1);
        flags_d.cy = flags_q.cy;
        flags_d.ac = (byte_q[3:0] != 4'h0);
      end
      acc_alu_pkg::OpCma: begin
        acc_d = ~acc_q;
      end
      acc_alu_pkg::OpDaa: begin
        acc_d      = sum9[7:0];
        flags_d    = add_flags;
        flags_d.cy = daa_cy;
      end
      acc_alu_pkg::OpInx: begin
        pair_res_d = pair_op_q + 16'd1;
      end
      acc_alu_pkg::OpDcx: begin
        pair_res_d = pair_op_q - 16'd1;
      end
      acc_alu_pkg::OpCmc: begin
        flags_d.cy = ~flags_q.cy;
      end
      acc_alu_pkg::OpStc: begin
        flags_d.cy = 1'b1;
      end
      default: begin
        // Unused codes change nothing.
      end
    endcase
  end

  // Commit state and load the result word together.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      flags_q     <= '0;
      pair_q      <= '0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
      if (in_valid_q) begin
        acc_q   <= acc_d;
        flags_q <= flags_d;
        pair_q  <= pair_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (execute) begin
      byte_res_q <= byte_res_d;
      pair_res_q <= pair_res_d;
    end
  end

  // State only moves on execute, so it is the result word while stalled.
  assign out_valid_o      = out_valid_q;
  assign acc_out_o        = acc_q;
  assign sign_flag_o      = flags_q.s;
  assign zero_flag_o      = flags_q.z;
  assign aux_carry_flag_o = flags_q.ac;
  assign parity_flag_o    = flags_q.p;
  assign carry_flag_o     = flags_q.cy;
  assign pair_out_o       = pair_q;
  assign byte_result_o    = byte_res_q;
  assign pair_result_o    = pair_res_q;

  // Qualifiers for the checks below.
  logic        out_held;
  logic        stc_exec;
  logic        cmp_exec;
  logic [28:0] state_word;

  assign out_held   = out_valid_q && out_stall_i;
  assign stc_exec   = execute && (op_q == acc_alu_pkg::OpStc);
  assign cmp_exec   = execute && (op_q == acc_alu_pkg::OpCmp);
  assign state_word = {acc_q, flags_q, pair_q};

  `ACC_ALU_ASSERT_IMPL(a_stall_needs_word, clk_i, rst_ni, in_stall_o, in_valid_q)
  `ACC_ALU_ASSERT_NEXT(a_hold_on_stall, clk_i, rst_ni, out_held, out_valid_q && $stable(state_word))
  `ACC_ALU_ASSERT_NEXT(a_stc_sets_carry, clk_i, rst_ni, stc_exec, flags_q.cy)
  `ACC_ALU_ASSERT_NEXT(a_cmp_keeps_acc, clk_i, rst_ni, cmp_exec, acc_q == $past(acc_q))

endmodule
